[hw/rtl/saw_pkg.sv]
`timescale 1ns / 1ps
// Package for the sawtooth oscillator: field widths, register indexes and
// the status struct of the shared divider. No dependencies.
package saw_pkg;

	// Widths of the item fields and of the configuration registers.
	localparam int LEVEL_W    = 16;
	localparam int FREQ_W     = 16;
	localparam int RATE_W     = 18;
	localparam int CFG_DATA_W = 18;
	localparam int CFG_IDX_W  = 2;

	// The sample rate times one hundred fits in this many bits.
	localparam int RATE_NUM_W = 25;
	// Phase plus the integer advance, before the modulo by the span.
	localparam int SUM_W      = 18;
	// The sample rate is given in hertz, the frequency in hundredths of a hertz.
	localparam int RATE_SCALE = 100;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LEVEL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 2'd2;

	// Reset values of the configuration registers.
	localparam logic signed [LEVEL_W-1:0] FIRST_LEVEL_RST  = -16'sd32768;
	localparam logic signed [LEVEL_W-1:0] SECOND_LEVEL_RST = 16'sd32767;
	localparam logic [RATE_W-1:0]         SAMPLE_RATE_RST  = 18'd44100;

	// Status of the shared divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[hw/rtl/saw_freq_if.sv]
`timescale 1ns / 1ps
// Input channel of the sawtooth oscillator: one frequency item per sample.
// Uses saw_pkg for the field width.
interface saw_freq_if;
	logic                         valid;
	logic                         ready;
	logic [saw_pkg::FREQ_W-1:0]   frequency;

	modport source (output valid, output frequency, input ready);
	modport sink (input valid, input frequency, output ready);
endinterface

[hw/rtl/saw_sample_if.sv]
`timescale 1ns / 1ps
// Output channel of the sawtooth oscillator: one signed sample per item.
// Uses saw_pkg for the field width.
interface saw_sample_if;
	logic                               valid;
	logic                               ready;
	logic signed [saw_pkg::LEVEL_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

[hw/rtl/saw_div.sv]
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle, for the oscillator.
// Depends on saw_pkg for the status struct.
module saw_div #(
	parameter int NUM_W  = 28,
	parameter int DEN_W  = 25,
	parameter int STEP_W = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   num,
	input  logic [DEN_W-1:0]   den,
	input  logic [STEP_W-1:0]  steps,
	output logic [NUM_W-1:0]   quot,
	output logic [DEN_W-1:0]   rem,
	output saw_pkg::div_stat_t stat
);

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              fits;
	logic [DEN_W-1:0]  rem_next;

	// One restoring step: bring down the next dividend bit and try to subtract.
	always_comb begin
		trial    = {rem_q, num_q[NUM_W-1]};
		diff     = trial - {1'b0, den_q};
		fits     = trial >= {1'b0, den_q};
		rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
	end

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign quot      = num_q;
	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// The done pulse closes a run and lasts one cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a preceding run");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

	// A start always opens a run.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider not busy after a start");

endmodule

[hw/rtl/sawtooth_oscillator.sv]
`timescale 1ns / 1ps
// Sawtooth oscillator on a phase accumulator. Each frequency item (hundredths
// of a hertz) yields one signed sample between the two configured levels; the
// ramp falls when the first level is above the second. Every division runs
// through one shared restoring divider, one bit per cycle, in three passes:
// the period quotient (25 bits), the phase advance (16 + FRACTION_BITS bits)
// and the phase modulo the span (18 bits). An item with nonzero frequency
// then runs through these passes in turn and a final step that moves the sample
// into the output register, and the input is ready again as the sample is offered;
// a zero frequency skips the divider and goes straight to the final step.
// The next item is taken once the sample has moved into the output register,
// where it may still wait, so a held output stalls the input.
// Depends on saw_pkg, saw_freq_if, saw_sample_if and saw_div.
module sawtooth_oscillator #(
	parameter int FRACTION_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [saw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [saw_pkg::CFG_DATA_W-1:0]      cfg_data,
	saw_freq_if.sink                            freq_ch,
	saw_sample_if.source                        sample_ch
);

	localparam int ADV_W  = saw_pkg::LEVEL_W + FRACTION_BITS;
	localparam int NUM_W  = (ADV_W > saw_pkg::RATE_NUM_W) ? ADV_W : saw_pkg::RATE_NUM_W;
	localparam int DEN_W  = saw_pkg::RATE_NUM_W;
	localparam int STEP_W = $clog2(NUM_W + 1);
	localparam int LW     = saw_pkg::LEVEL_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUOT,
		ST_ADV,
		ST_MOD,
		ST_DONE
	} state_t;

	state_t                    state_q;
	logic signed [LW-1:0]      first_q;
	logic signed [LW-1:0]      second_q;
	logic [saw_pkg::RATE_W-1:0] rate_q;
	logic [LW-1:0]             phase_q;
	logic [FRACTION_BITS-1:0]  frac_q;
	logic [LW-1:0]             span_q;
	logic [LW-1:0]             sample_q;
	logic [LW-1:0]             out_q;
	logic                      out_valid_q;

	logic                      accept;
	logic                      falling;
	logic signed [LW-1:0]      lo;
	logic signed [LW-1:0]      hi;
	logic [LW:0]               span_raw;
	logic [LW-1:0]             span;
	logic [LW-1:0]             sample_calc;
	logic [DEN_W-1:0]          rate_x100;
	logic [DEN_W-1:0]          quot_fix;
	logic [ADV_W:0]            adv;
	logic [saw_pkg::SUM_W-1:0] sum;

	logic                      div_start;
	logic [NUM_W-1:0]          div_num;
	logic [DEN_W-1:0]          div_den;
	logic [STEP_W-1:0]         div_steps;
	logic [NUM_W-1:0]          div_quot;
	logic [DEN_W-1:0]          div_rem;
	saw_pkg::div_stat_t        div_stat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= saw_pkg::FIRST_LEVEL_RST;
			second_q <= saw_pkg::SECOND_LEVEL_RST;
			rate_q   <= saw_pkg::SAMPLE_RATE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				saw_pkg::CFG_FIRST_LEVEL:  first_q  <= cfg_data[LW-1:0];
				saw_pkg::CFG_SECOND_LEVEL: second_q <= cfg_data[LW-1:0];
				saw_pkg::CFG_SAMPLE_RATE:  rate_q   <= cfg_data[saw_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// Level sorting, span and the sample for the current phase.
	always_comb begin
		falling     = first_q > second_q;
		lo          = falling ? second_q : first_q;
		hi          = falling ? first_q : second_q;
		span_raw    = {hi[LW-1], hi} - {lo[LW-1], lo};
		span        = (span_raw[LW-1:0] == '0) ? LW'(1) : span_raw[LW-1:0];
		sample_calc = falling ? (hi - phase_q) : (phase_q + lo);
		rate_x100   = DEN_W'(rate_q) * DEN_W'(saw_pkg::RATE_SCALE);
	end

	assign accept = freq_ch.valid && freq_ch.ready;

	// Results of the divider passes.
	always_comb begin
		quot_fix = (div_quot[DEN_W-1:0] == '0) ? DEN_W'(1) : div_quot[DEN_W-1:0];
		adv      = (ADV_W + 1)'(div_quot[ADV_W-1:0]) + (ADV_W + 1)'(frac_q);
		sum      = saw_pkg::SUM_W'(phase_q) + saw_pkg::SUM_W'(adv[ADV_W:FRACTION_BITS]);
	end

	// Operand selection for the shared divider; dividends are left-aligned.
	always_comb begin
		div_start = 1'b0;
		div_num   = NUM_W'(rate_x100) << (NUM_W - saw_pkg::RATE_NUM_W);
		div_den   = DEN_W'(freq_ch.frequency);
		div_steps = STEP_W'(saw_pkg::RATE_NUM_W);
		case (state_q)
			ST_IDLE: begin
				div_start = accept && (freq_ch.frequency != '0);
			end
			ST_QUOT: begin
				div_start = div_stat.done;
				div_num   = (NUM_W'(span_q) << FRACTION_BITS) << (NUM_W - ADV_W);
				div_den   = quot_fix;
				div_steps = STEP_W'(ADV_W);
			end
			ST_ADV: begin
				div_start = div_stat.done;
				div_num   = NUM_W'(sum) << (NUM_W - saw_pkg::SUM_W);
				div_den   = DEN_W'(span_q);
				div_steps = STEP_W'(saw_pkg::SUM_W);
			end
			default: ;
		endcase
	end

	saw_div #(
		.NUM_W  (NUM_W),
		.DEN_W  (DEN_W),
		.STEP_W (STEP_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.quot   (div_quot),
		.rem    (div_rem),
		.stat   (div_stat)
	);

	// Sequencer with phase state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			frac_q      <= '0;
			span_q      <= '0;
			sample_q    <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The final step reloads the output register itself.
			if (sample_ch.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						span_q <= span;
						if (freq_ch.frequency == '0) begin
							sample_q <= '0;
							phase_q  <= '0;
							frac_q   <= '0;
							state_q  <= ST_DONE;
						end else begin
							sample_q <= sample_calc;
							state_q  <= ST_QUOT;
						end
					end
				end
				ST_QUOT: begin
					if (div_stat.done) begin
						state_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					if (div_stat.done) begin
						frac_q  <= adv[FRACTION_BITS-1:0];
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (div_stat.done) begin
						phase_q <= div_rem[LW-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || sample_ch.ready) begin
						out_q       <= sample_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign freq_ch.ready    = (state_q == ST_IDLE);
	assign sample_ch.valid  = out_valid_q;
	assign sample_ch.sample = out_q;

	// The divider is only started when it is free.
	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// A silent item clears the phase and fraction.
	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (freq_ch.frequency == '0) |=> (phase_q == '0) && (frac_q == '0))
		else $error("zero frequency did not clear the phase");

	// A new sample is only offered at the end of an item.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("sample offered outside the final step");

endmodule

[tb/sawtooth_oscillator_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sawtooth_oscillator: sends frequency items, predicts
// each sample with its own phase accumulator and compares every sample item.
// Depends on saw_pkg, saw_freq_if, saw_sample_if and the oscillator RTL.
module sawtooth_oscillator_test;

	localparam int FRAC_BITS    = 12;
	localparam int FRAC_ONE     = 1 << FRAC_BITS;
	localparam int IDLE_PCT     = 26;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int MAX_REPORTS  = 10;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_ITEMS  = 100;
	localparam int EXT_W        = saw_pkg::CFG_DATA_W - saw_pkg::LEVEL_W;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [saw_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [saw_pkg::CFG_DATA_W-1:0] cfg_data;

	saw_freq_if   freq_ch ();
	saw_sample_if sample_ch ();

	sawtooth_oscillator #(.FRACTION_BITS(FRAC_BITS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.freq_ch   (freq_ch),
		.sample_ch (sample_ch)
	);

	// Shadow copy of the registers and of the accumulator state.
	logic signed [saw_pkg::LEVEL_W-1:0] osc_first;
	logic signed [saw_pkg::LEVEL_W-1:0] osc_second;
	logic [saw_pkg::RATE_W-1:0]         osc_rate;
	logic [saw_pkg::LEVEL_W-1:0]        osc_phase;
	logic [FRAC_BITS-1:0]               osc_frac;

	logic signed [saw_pkg::LEVEL_W-1:0] pending_samples[$];
	logic signed [saw_pkg::LEVEL_W-1:0] oldest_sample;
	int unsigned                        mismatches = 0;
	int unsigned                        cycles = 0;
	bit                                 steady = 1'b0;

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Computes the sample for one frequency and advances the shadow phase.
	function automatic logic signed [saw_pkg::LEVEL_W-1:0] next_saw_sample(
		input logic [saw_pkg::FREQ_W-1:0] f);
		logic                               falling;
		logic signed [saw_pkg::LEVEL_W-1:0] lo;
		logic signed [saw_pkg::LEVEL_W-1:0] hi;
		logic [63:0]                        span;
		logic [63:0]                        period;
		logic [63:0]                        advance;
		logic [63:0]                        wrapped;
		logic [saw_pkg::LEVEL_W-1:0]        level_out;
		falling = osc_first > osc_second;
		lo = falling ? osc_second : osc_first;
		hi = falling ? osc_first : osc_second;
		span = 64'(int'(hi) - int'(lo));
		if (span == 0)
			span = 1;
		// A zero frequency silences the output and restarts the ramp.
		if (f == '0) begin
			osc_phase = '0;
			osc_frac = '0;
			return '0;
		end
		if (falling)
			level_out = hi - osc_phase;
		else
			level_out = osc_phase + lo;
		period = (64'(osc_rate) * saw_pkg::RATE_SCALE) / 64'(f);
		if (period == 0)
			period = 1;
		advance = (span * FRAC_ONE) / period + 64'(osc_frac);
		wrapped = (64'(osc_phase) + (advance >> FRAC_BITS)) % span;
		osc_phase = wrapped[saw_pkg::LEVEL_W-1:0];
		osc_frac = advance[FRAC_BITS-1:0];
		return level_out;
	endfunction

	// Writes one register and mirrors it in the shadow copy.
	task automatic write_reg(input logic [saw_pkg::CFG_IDX_W-1:0] idx,
		input logic [saw_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			saw_pkg::CFG_FIRST_LEVEL:  osc_first = value[saw_pkg::LEVEL_W-1:0];
			saw_pkg::CFG_SECOND_LEVEL: osc_second = value[saw_pkg::LEVEL_W-1:0];
			saw_pkg::CFG_SAMPLE_RATE:  osc_rate = value[saw_pkg::RATE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_levels(input logic [saw_pkg::LEVEL_W-1:0] first,
		input logic [saw_pkg::LEVEL_W-1:0] second);
		write_reg(saw_pkg::CFG_FIRST_LEVEL,
			{{EXT_W{first[saw_pkg::LEVEL_W-1]}}, first});
		write_reg(saw_pkg::CFG_SECOND_LEVEL,
			{{EXT_W{second[saw_pkg::LEVEL_W-1]}}, second});
	endtask

	task automatic set_rate(input logic [saw_pkg::RATE_W-1:0] rate);
		write_reg(saw_pkg::CFG_SAMPLE_RATE, saw_pkg::CFG_DATA_W'(rate));
	endtask

	// Offers one frequency item, after a random gap unless steady, and records its sample.
	task automatic send_freq(input logic [saw_pkg::FREQ_W-1:0] f);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			freq_ch.valid <= 1'b0;
			@(posedge clk);
		end
		freq_ch.valid <= 1'b1;
		freq_ch.frequency <= f;
		do @(posedge clk); while (!freq_ch.ready);
		pending_samples.push_back(next_saw_sample(f));
	endtask

	// Holds the sender until every predicted sample has come back.
	task automatic wait_samples_drained();
		freq_ch.valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [saw_pkg::FREQ_W-1:0] pick_frequency();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return '0;
		if (roll < 25)
			return saw_pkg::FREQ_W'($urandom_range(1, 2000));
		if (roll < 30)
			return '1;
		return saw_pkg::FREQ_W'($urandom_range(1, 65535));
	endfunction

	function automatic logic [saw_pkg::LEVEL_W-1:0] pick_level();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return '0;
			default: return saw_pkg::LEVEL_W'($urandom());
		endcase
	endfunction

	function automatic logic [saw_pkg::RATE_W-1:0] pick_rate();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			2, 3: return saw_pkg::RATE_W'(1);
			4, 5: return saw_pkg::RATE_W'(192000);
			6: return saw_pkg::RATE_W'(44100);
			default: return saw_pkg::RATE_W'($urandom_range(1, 192000));
		endcase
	endfunction

	// Rising ramp with the reset levels and rate, zero frequency included.
	task automatic test_reset_levels();
		send_freq('0);
		send_freq(16'd1);
		send_freq(16'd44000);
		send_freq('1);
		send_freq(16'h5555);
		send_freq(16'haaaa);
		send_freq('0);
		send_freq(16'd30000);
		wait_samples_drained();
	endtask

	// First level above the second turns the ramp downward.
	task automatic test_falling_ramp();
		set_levels(16'h7fff, 16'h8000);
		send_freq('1);
		send_freq('1);
		send_freq(16'd12345);
		wait_samples_drained();
	endtask

	// Equal levels give a span of one, so the phase never moves.
	task automatic test_equal_levels();
		set_levels(16'd1000, 16'd1000);
		send_freq(16'd50000);
		send_freq(16'd50000);
		wait_samples_drained();
	endtask

	// Zero and tiny period quotients, and the largest rates.
	task automatic test_period_extremes();
		set_levels(16'h8000, 16'h7fff);
		set_rate('0);
		send_freq(16'd100);
		send_freq('1);
		wait_samples_drained();
		set_rate(saw_pkg::RATE_W'(1));
		send_freq('1);
		send_freq(16'd50);
		wait_samples_drained();
		set_rate('1);
		send_freq(16'd1);
		wait_samples_drained();
		set_rate(saw_pkg::RATE_W'(192000));
		send_freq('1);
		wait_samples_drained();
	endtask

	// Narrowing the levels under a large phase makes the output wrap once.
	task automatic test_level_change();
		set_levels(16'h8000, 16'h7fff);
		set_rate(saw_pkg::RATE_W'(1000));
		send_freq('0);
		send_freq(16'd40000);
		wait_samples_drained();
		set_levels(16'd30000, 16'd30100);
		send_freq(16'd40000);
		send_freq(16'd40000);
		wait_samples_drained();
	endtask

	// Random settings per phase; most items hold a steady tone, the rest jump.
	task automatic test_random_phases();
		logic [saw_pkg::FREQ_W-1:0] tone;
		for (int p = 0; p < RAND_PHASES; p++) begin
			set_levels(pick_level(), pick_level());
			set_rate(pick_rate());
			tone = pick_frequency();
			steady = (p == 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 3) == 0)
					send_freq(pick_frequency());
				else
					send_freq(tone);
			end
			wait_samples_drained();
		end
		steady = 1'b0;
	endtask

	// Random back pressure on the sample side, none while steady, and the check of each sample item.
	always @(posedge clk) begin
		if (sample_ch.valid && sample_ch.ready) begin
			if (pending_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected sample %0d with none pending", sample_ch.sample);
			end else begin
				oldest_sample = pending_samples.pop_front();
				if (sample_ch.sample !== oldest_sample) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("sample mismatch: expected %0d, got %0d",
							oldest_sample, sample_ch.sample);
				end
			end
		end
		sample_ch.ready <= arst_n && (steady || ($urandom_range(0, 99) >= IDLE_PCT));
	end

	// Ends a run that hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("sawtooth_oscillator_test failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= saw_pkg::CFG_FIRST_LEVEL;
		cfg_data <= '0;
		freq_ch.valid <= 1'b0;
		freq_ch.frequency <= '0;
		osc_first = saw_pkg::FIRST_LEVEL_RST;
		osc_second = saw_pkg::SECOND_LEVEL_RST;
		osc_rate = saw_pkg::SAMPLE_RATE_RST;
		osc_phase = '0;
		osc_frac = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_levels();
		test_falling_ramp();
		test_equal_levels();
		test_period_extremes();
		test_level_change();
		test_random_phases();

		wait_samples_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += pending_samples.size();
		if (mismatches == 0)
			$display("sawtooth_oscillator_test passed");
		else
			$display("sawtooth_oscillator_test failed");
		$finish;
	end

endmodule
